@@ hw/rtl/tcd_pkg.sv @@
// Package: character codes, fixed-point constants, pipeline types and parser helpers.
package tcd_pkg;

    localparam int BUF_SIZE_DEF = 64;
    localparam logic [2:0] FRAC_DIGITS = 3'd5;

    localparam int INT_W  = 16;
    localparam int FRAC_W = 17;
    localparam int DIG_W  = 3;
    localparam int X_W    = 28;
    localparam int M_W    = 29;
    localparam int PROD_W = X_W + M_W;
    localparam int SH_W   = 6;
    localparam int Q_W    = 32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_R     = 8'h52;

    localparam logic [7:0] RESET_WORD [5] = '{8'h72, 8'h65, 8'h73, 8'h65, 8'h74};
    localparam logic [2:0] RST_LAST = 3'd4;

    localparam logic signed [Q_W-1:0] Q_H_LOW  = 32'sd6553;
    localparam logic signed [Q_W-1:0] Q_H_HIGH = 32'sd196608;
    localparam logic signed [Q_W-1:0] Q_O_HIGH = 32'sd1310720;
    localparam logic signed [Q_W-1:0] Q_P_HIGH = 32'sd524288;
    localparam logic signed [INT_W-1:0] IV_G_LOW  = 16'sd1;
    localparam logic signed [INT_W-1:0] IV_G_HIGH = 16'sd3;

    typedef enum logic [1:0] {
        PH_SIGN = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_RESET = 1'b1
    } t_kind;

    typedef struct packed {
        t_phase             phase;
        logic               neg;
        logic [INT_W-1:0]   int_acc;
        logic [FRAC_W-1:0]  frac_acc;
        logic [DIG_W-1:0]   digs;
    } t_num;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         letter;
        logic               comma;
        t_num [1:0]         num;
    } t_snap;

    typedef struct packed {
        t_kind                      kind;
        logic [7:0]                 letter;
        logic                       comma;
        logic [1:0]                 neg;
        logic [1:0][INT_W-1:0]      int_acc;
        logic [1:0][DIG_W-1:0]      digs;
        logic [1:0][PROD_W-1:0]     prod;
    } t_prod;

    typedef struct packed {
        t_kind                      kind;
        logic [7:0]                 letter;
        logic                       comma;
        logic signed [Q_W-1:0]      q0;
        logic signed [Q_W-1:0]      q1;
        logic signed [INT_W-1:0]    iv;
    } t_qval;

    // reciprocal of 5^d scaled by 2^shift(d), rounded up
    function automatic logic [M_W-1:0] recip(input logic [DIG_W-1:0] d);
        logic [M_W-1:0] m;
        case (d)
            3'd1:    m = 29'd419431;
            3'd2:    m = 29'd2684355;
            3'd3:    m = 29'd8589935;
            3'd4:    m = 29'd54975582;
            3'd5:    m = 29'd351843721;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [SH_W-1:0] recip_shift(input logic [DIG_W-1:0] d);
        logic [SH_W-1:0] s;
        case (d)
            3'd1:    s = 6'd21;
            3'd2:    s = 6'd26;
            3'd3:    s = 6'd30;
            3'd4:    s = 6'd35;
            3'd5:    s = 6'd40;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_plain_letter(input logic [7:0] c);
        return c inside {[CH_A:CH_F], CH_I, [CH_L:CH_N], CH_Q, CH_R};
    endfunction

    function automatic logic [INT_W-1:0] add_int_digit(input logic [INT_W-1:0] acc,
                                                       input logic [3:0] dig);
        logic [19:0] v;
        v = {4'b0, acc} * 20'd10 + {16'b0, dig};
        return (v > 20'd65535) ? 16'hFFFF : v[INT_W-1:0];
    endfunction

    function automatic t_num feed_num(input t_num cur, input logic [7:0] c);
        t_num nxt;
        logic dig;
        nxt = cur;
        dig = is_digit(c);
        case (cur.phase)
            PH_SIGN: begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    nxt.phase = PH_SIGN;
                end else if (c == CH_MINUS) begin
                    nxt.neg   = 1'b1;
                    nxt.phase = PH_INT;
                end else if (c == CH_PLUS) begin
                    nxt.phase = PH_INT;
                end else if (dig) begin
                    nxt.int_acc = add_int_digit(cur.int_acc, c[3:0]);
                    nxt.phase   = PH_INT;
                end else if (c == CH_DOT) begin
                    nxt.phase = PH_FRAC;
                end else begin
                    nxt.phase = PH_DONE;
                end
            end
            PH_INT: begin
                if (dig) begin
                    nxt.int_acc = add_int_digit(cur.int_acc, c[3:0]);
                end else if (c == CH_DOT) begin
                    nxt.phase = PH_FRAC;
                end else begin
                    nxt.phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (dig) begin
                    if (cur.digs < FRAC_DIGITS) begin
                        nxt.frac_acc = cur.frac_acc * 17'd10 + {13'b0, c[3:0]};
                        nxt.digs     = cur.digs + 3'd1;
                    end
                end else begin
                    nxt.phase = PH_DONE;
                end
            end
            default: begin
                nxt.phase = PH_DONE;
            end
        endcase
        return nxt;
    endfunction

endpackage

@@ hw/rtl/tcd_byte_if.sv @@
// Interface: received byte channel.
interface tcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

@@ hw/rtl/tcd_result_if.sv @@
// Interface: decoded result channel.
interface tcd_result_if;
    import tcd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       result_kind;
    logic [7:0]                 command_letter;
    logic                       has_pair;
    logic signed [Q_W-1:0]      first_value;
    logic signed [Q_W-1:0]      second_value;
    logic signed [INT_W-1:0]    integer_value;
    logic                       accepted;

    modport source (output valid, output result_kind, output command_letter,
                    output has_pair, output first_value, output second_value,
                    output integer_value, output accepted, input ready);
    modport sink   (input valid, input result_kind, input command_letter,
                    input has_pair, input first_value, input second_value,
                    input integer_value, input accepted, output ready);
endinterface

@@ hw/rtl/text_tuning_command_decoder.sv @@
// Top level: text tuning command decoder, byte parser and four-stage result pipeline.
//
//  channel    dir  payload
//  i_byte     in   byte_in (8)
//  o_result   out  result_kind, command_letter, has_pair, first_value,
//                  second_value, integer_value, accepted
//
// One byte is taken every cycle while i_byte.ready is high; the parser state updates in the accept cycle.
// A result passes from the byte that causes it through the snapshot register, the fraction
// scaling multiplier and its shift and saturate stage into the check stage's output register.
// Reset clears parser, matcher and pipeline valid bits; nothing else needs it.
// A stalled output holds; input keeps flowing while an empty pipeline stage remains.
module text_tuning_command_decoder #(
    parameter int BUF_SIZE = tcd_pkg::BUF_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tcd_byte_if.sink       i_byte,
    tcd_result_if.source   o_result
);
    import tcd_pkg::*;

    localparam int CNT_W = $clog2(BUF_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUF_SIZE - 1);
    localparam logic [CNT_W-1:0] IDX_LETTER = CNT_W'(1);
    localparam logic [CNT_W-1:0] IDX_FIRST  = CNT_W'(2);

    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_letter, n_letter;
    logic             r_text_ended, n_text_ended;
    logic             r_comma, n_comma;
    t_num             r_num [2];
    t_num             n_num [2];
    logic [2:0]       r_rst_cnt, n_rst_cnt;
    logic             r_rst_ok, n_rst_ok;

    logic             rst_hit, emit_frame, acc;
    logic             rdy1, rdy2, rdy3, rdy4;
    logic [7:0]       c;

    logic             r_v1, r_v2, r_v3, r_v4;
    t_snap            r_s1, n_s1;
    t_prod            r_s2, n_s2;
    t_qval            r_s3, n_s3;
    t_qval            r_s4;
    logic             r_acc4, n_acc4;

    assign c    = i_byte.byte_in;
    assign rdy4 = !r_v4 || o_result.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_byte.ready = rdy1;
    assign acc  = i_byte.valid && rdy1;

    always_comb begin
        logic ok_t;
        n_rst_cnt = r_rst_cnt;
        n_rst_ok  = r_rst_ok;
        rst_hit   = 1'b0;
        ok_t      = 1'b0;
        if (r_rst_cnt == 3'd0) begin
            if (c == RESET_WORD[0]) begin
                n_rst_cnt = 3'd1;
                n_rst_ok  = 1'b1;
            end
        end else begin
            ok_t = r_rst_ok && (c == RESET_WORD[r_rst_cnt]);
            if (r_rst_cnt == RST_LAST) begin
                n_rst_cnt = 3'd0;
                n_rst_ok  = 1'b0;
                rst_hit   = ok_t;
            end else begin
                n_rst_cnt = r_rst_cnt + 3'd1;
                n_rst_ok  = ok_t;
            end
        end
    end

    always_comb begin
        n_in_frame   = r_in_frame;
        n_count      = r_count;
        n_letter     = r_letter;
        n_text_ended = r_text_ended;
        n_comma      = r_comma;
        n_num[0]     = r_num[0];
        n_num[1]     = r_num[1];
        emit_frame   = (c == CH_LF) && r_in_frame;
        if (c == CH_LF || c == CH_HASH) begin
            n_in_frame   = (c == CH_HASH);
            n_count      = (c == CH_HASH) ? IDX_LETTER : '0;
            n_letter     = '0;
            n_text_ended = 1'b0;
            n_comma      = 1'b0;
            n_num[0]     = '0;
            n_num[1]     = '0;
        end else if (r_in_frame && r_count < CNT_LAST) begin
            n_count = r_count + IDX_LETTER;
            if (!r_text_ended) begin
                if (c == CH_NUL) begin
                    n_text_ended = 1'b1;
                end else begin
                    if (r_count == IDX_LETTER) begin
                        n_letter = c;
                    end
                    if (r_comma) begin
                        n_num[1] = feed_num(r_num[1], c);
                    end
                    if (r_count >= IDX_FIRST) begin
                        n_num[0] = feed_num(r_num[0], c);
                    end
                    if (c == CH_COMMA) begin
                        n_comma = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        n_s1 = '0;
        if (emit_frame) begin
            n_s1.kind   = KIND_FRAME;
            n_s1.letter = r_letter;
            n_s1.comma  = r_comma;
            n_s1.num[0] = r_num[0];
            n_s1.num[1] = r_num[1];
        end else begin
            n_s1.kind = KIND_RESET;
        end
    end

    always_comb begin
        logic [32:0]    xw;
        logic [X_W-1:0] x;
        n_s2.kind   = r_s1.kind;
        n_s2.letter = r_s1.letter;
        n_s2.comma  = r_s1.comma;
        xw = '0;
        x  = '0;
        for (int k = 0; k < 2; k++) begin
            n_s2.neg[k]     = r_s1.num[k].neg;
            n_s2.int_acc[k] = r_s1.num[k].int_acc;
            n_s2.digs[k]    = r_s1.num[k].digs;
            xw = {16'b0, r_s1.num[k].frac_acc} << (5'd16 - {2'b0, r_s1.num[k].digs});
            x  = xw[X_W-1:0];
            n_s2.prod[k] = {{M_W{1'b0}}, x} * {{X_W{1'b0}}, recip(r_s1.num[k].digs)};
        end
    end

    always_comb begin
        logic [PROD_W-1:0]      sh;
        logic [Q_W-1:0]         mag;
        logic [Q_W-1:0]         q [2];
        logic [INT_W-1:0]       m;
        sh = '0;
        mag = '0;
        for (int k = 0; k < 2; k++) begin
            sh  = r_s2.prod[k] >> recip_shift(r_s2.digs[k]);
            mag = {r_s2.int_acc[k], sh[INT_W-1:0]};
            if (r_s2.neg[k]) begin
                q[k] = mag[Q_W-1] ? 32'h8000_0000 : (32'd0 - mag);
            end else begin
                q[k] = mag[Q_W-1] ? 32'h7FFF_FFFF : mag;
            end
        end
        m = r_s2.int_acc[0];
        n_s3.kind   = r_s2.kind;
        n_s3.letter = r_s2.letter;
        n_s3.comma  = r_s2.comma;
        n_s3.q0     = q[0];
        n_s3.q1     = q[1];
        if (r_s2.neg[0]) begin
            n_s3.iv = (m > 16'd32768) ? 16'h8000 : (16'd0 - m);
        end else begin
            n_s3.iv = (m > 16'd32767) ? 16'h7FFF : m;
        end
    end

    always_comb begin
        n_acc4 = 1'b0;
        if (r_s3.comma) begin
            n_acc4 = (r_s3.letter == CH_J) || (r_s3.letter == CH_K);
        end else if (is_plain_letter(r_s3.letter)) begin
            n_acc4 = 1'b1;
        end else begin
            case (r_s3.letter)
                CH_G:    n_acc4 = (r_s3.iv >= IV_G_LOW) && (r_s3.iv <= IV_G_HIGH);
                CH_H:    n_acc4 = (r_s3.q0 > Q_H_LOW) && (r_s3.q0 < Q_H_HIGH);
                CH_O:    n_acc4 = (r_s3.q0 >= 32'sd0) && (r_s3.q0 <= Q_O_HIGH);
                CH_P:    n_acc4 = (r_s3.q0 >= 32'sd0) && (r_s3.q0 <= Q_P_HIGH);
                default: n_acc4 = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_count      <= '0;
            r_letter     <= '0;
            r_text_ended <= 1'b0;
            r_comma      <= 1'b0;
            r_num[0]     <= '0;
            r_num[1]     <= '0;
            r_rst_cnt    <= '0;
            r_rst_ok     <= 1'b0;
        end else if (acc) begin
            r_in_frame   <= n_in_frame;
            r_count      <= n_count;
            r_letter     <= n_letter;
            r_text_ended <= n_text_ended;
            r_comma      <= n_comma;
            r_num[0]     <= n_num[0];
            r_num[1]     <= n_num[1];
            r_rst_cnt    <= n_rst_cnt;
            r_rst_ok     <= n_rst_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= acc && (emit_frame || rst_hit);
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1 <= n_s1;
        end
        if (rdy2) begin
            r_s2 <= n_s2;
        end
        if (rdy3) begin
            r_s3 <= n_s3;
        end
        if (rdy4) begin
            r_s4   <= r_s3;
            r_acc4 <= n_acc4;
        end
    end

    assign o_result.valid          = r_v4;
    assign o_result.result_kind    = r_s4.kind;
    assign o_result.command_letter = r_s4.letter;
    assign o_result.has_pair       = r_s4.comma;
    assign o_result.first_value    = r_s4.q0;
    assign o_result.second_value   = r_s4.q1;
    assign o_result.integer_value  = r_s4.iv;
    assign o_result.accepted       = r_acc4;

endmodule
